@@ hdl/swpd_pkg.sv @@
// Shared types and constants for the sync word packet deframer.
package swpd_pkg;

   localparam logic [63:0] SYNC_PATTERN = 64'h0101_AA55_0101_0101;
   localparam int          SYNC_LEN     = 8;
   localparam logic [15:0] GAP_MAX      = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [15:0] word_value;
      logic [3:0]  word_index;
      logic        packet_status;
      logic [15:0] sync_gap;
      logic        last_of_packet;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        drop;
      logic        bank;
      logic [15:0] gap;
   } job_type;

endpackage

@@ hdl/swpd_emitter.sv @@
// Packet word memory and result sequencer with registered output beat.
module swpd_emitter #(
   parameter int WORDS_PER_PACKET = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  swpd_pkg::job_type          job,
   input  logic                       wr_en,
   input  logic [$clog2(2*WORDS_PER_PACKET)-1:0] wr_addr,
   input  logic [15:0]                wr_data,
   output logic                       busy,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output swpd_pkg::rsp_type          rsp
);
   import swpd_pkg::*;

   localparam int W  = WORDS_PER_PACKET;
   localparam int IW = (W > 1) ? $clog2(W) : 1;
   localparam int AW = $clog2(2 * W);

   logic [15:0]   mem [2*W];
   logic [15:0]   rd_ff;

   logic          job_active_ff;
   logic          job_drop_ff;
   logic          job_bank_ff;
   logic [IW-1:0] job_idx_ff;
   logic [15:0]   job_gap_ff;

   logic          rsp_valid_ff;
   logic [3:0]    out_idx_ff;
   logic          out_drop_ff;
   logic [15:0]   out_gap_ff;
   logic          out_last_ff;

   logic          advance;
   logic          job_last;
   logic [AW-1:0] rd_addr;

   assign advance  = job_active_ff && (!rsp_valid_ff || rsp_ready);
   assign job_last = job_drop_ff || (job_idx_ff == IW'(W - 1));
   assign rd_addr  = job_bank_ff ? (AW'(W) + AW'(job_idx_ff)) : AW'(job_idx_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (advance) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (job.valid) begin
            job_active_ff <= 1'b1;
         end else if (advance && job_last) begin
            job_active_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job.valid) begin
         job_drop_ff <= job.drop;
         job_bank_ff <= job.bank;
         job_gap_ff  <= job.gap;
         job_idx_ff  <= '0;
      end else if (advance) begin
         job_idx_ff <= job_idx_ff + IW'(1);
      end
      if (advance) begin
         out_idx_ff  <= 4'(job_idx_ff);
         out_drop_ff <= job_drop_ff;
         out_gap_ff  <= job_gap_ff;
         out_last_ff <= job_last;
      end
   end

   assign busy      = job_active_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp.word_value     = out_drop_ff ? 16'h0000 : rd_ff;
      rsp.word_index     = out_idx_ff;
      rsp.packet_status  = out_drop_ff;
      rsp.sync_gap       = out_gap_ff;
      rsp.last_of_packet = out_last_ff;
   end

endmodule

@@ hdl/sync_word_packet_deframer.sv @@
// Top level of the sync word packet deframer: sync search, capture and result hand-off.
// A closing byte's job is registered in the sequencer before its first result beat is registered.
// Throughput: one byte per cycle, but a sync or end-of-stream byte waits while a drain is
// open; a kept packet drains as WORDS_PER_PACKET beats from a two-bank word memory.
// Reset: synchronous; clears the window, sync flag, counters and the result sequencer.
// The end-of-stream byte returns the window, sync flag and counters to their reset values, but not the bank select.
module sync_word_packet_deframer #(
   parameter int WORDS_PER_PACKET = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swpd_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output swpd_pkg::rsp_type rsp
);
   import swpd_pkg::*;

   localparam int W        = WORDS_PER_PACKET;
   localparam int AW       = $clog2(2 * W);
   localparam int CW       = $clog2(2 * W + 1);
   localparam int GOOD_GAP = SYNC_LEN + 2 * W;

   logic [63:0]   window_ff,    window_in;
   logic          have_sync_ff, have_sync_in;
   logic [15:0]   bss_ff,       bss_in;
   logic [CW-1:0] cap_ff,       cap_in;
   logic          bank_ff,      bank_in;
   logic [7:0]    hi_ff,        hi_in;

   logic          accept;
   logic          sync_hit;
   logic          cap_full;
   logic [15:0]   gap;
   logic          emit_busy;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   job_type       job;

   assign sync_hit  = ({window_ff[55:0], req.data_byte} == SYNC_PATTERN);
   assign cap_full  = (cap_ff == CW'(2 * W));
   assign gap       = (bss_ff == GAP_MAX) ? GAP_MAX : (bss_ff + 16'd1);
   assign req_ready = !(emit_busy && (sync_hit || req.end_of_stream));
   assign accept    = req_valid && req_ready;
   assign wr_addr   = bank_ff ? (AW'(W) + AW'(cap_ff[CW-1:1])) : AW'(cap_ff[CW-1:1]);
   assign wr_data   = {hi_ff, req.data_byte};

   always_comb begin
      window_in    = {window_ff[55:0], req.data_byte};
      have_sync_in = have_sync_ff;
      bss_in       = bss_ff;
      cap_in       = cap_ff;
      bank_in      = bank_ff;
      hi_in        = hi_ff;
      wr_en        = 1'b0;
      job          = '{valid: 1'b0, drop: 1'b0, bank: bank_ff, gap: gap};

      if (sync_hit) begin
         if (have_sync_ff) begin
            job.valid = accept;
            job.drop  = !((gap == 16'(GOOD_GAP)) && cap_full);
         end
         have_sync_in = 1'b1;
         bss_in       = '0;
         cap_in       = '0;
         bank_in      = !bank_ff;
      end else if (have_sync_ff) begin
         if (bss_ff != GAP_MAX) begin
            bss_in = bss_ff + 16'd1;
         end
         if (!cap_full) begin
            if (!cap_ff[0]) begin
               hi_in = req.data_byte;
            end else begin
               wr_en = accept;
            end
            cap_in = cap_ff + CW'(1);
         end
      end

      if (req.end_of_stream) begin
         if (!sync_hit && have_sync_ff && (cap_in == CW'(2 * W))) begin
            job.valid = accept;
            job.drop  = 1'b0;
            job.gap   = bss_in;
         end
         window_in    = '0;
         have_sync_in = 1'b0;
         bss_in       = '0;
         cap_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         have_sync_ff <= 1'b0;
         bss_ff       <= '0;
         cap_ff       <= '0;
         bank_ff      <= 1'b0;
      end else if (accept) begin
         window_ff    <= window_in;
         have_sync_ff <= have_sync_in;
         bss_ff       <= bss_in;
         cap_ff       <= cap_in;
         bank_ff      <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hi_ff <= hi_in;
      end
   end

   swpd_emitter #(
      .WORDS_PER_PACKET(W)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .busy      (emit_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_job_when_idle: assert property (@(posedge clock) disable iff (reset)
      job.valid |-> !emit_busy)
      else $error("result job started while sequencer busy");

   a_sync_when_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && sync_hit) |-> !emit_busy)
      else $error("sync beat taken while a packet drains");

   a_drop_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.packet_status) |-> (rsp.last_of_packet && rsp.word_index == 4'd0))
      else $error("drop beat not marked last");

   a_job_then_rsp: assert property (@(posedge clock) disable iff (reset)
      job.valid |=> emit_busy)
      else $error("started job not held by sequencer");

endmodule
